>>> sv/trm_pkg.sv
// Shared types, widths and constants for the tilt-rotor thrust mixer.
package trm_pkg;

    // Default number of CORDIC micro-rotations and the length of the arctangent table.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    // Datapath widths: CORDIC x/y with 14 fraction bits, angle in Q2.30.
    localparam int XW    = 26;
    localparam int ZW    = 34;
    localparam int TVW   = 22;
    localparam int THW   = 36;
    localparam int GAINW = 16;
    localparam int PRODW = XW - 1 + GAINW;

    // Stream widths.
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 128;

    // Fixed-point constants.
    localparam logic signed [17:0]    SQRT2_Q16    = 18'sd92682;
    localparam logic [GAINW-1:0]      INV_GAIN_Q16 = 16'd39797;
    localparam logic signed [ZW-1:0]  HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [15:0]    ANGLE_MAX    = 16'sd12868;

    // atan(2^-i) in Q2.30, truncated.
    localparam logic [ZW-1:0] ATAN_Q30 [TABLE_LEN] = '{
        34'h03243F6A8, 34'h01DAC6705, 34'h00FADBAFC, 34'h007F56EA6,
        34'h003FEAB76, 34'h001FFD55B, 34'h000FFFAAA, 34'h0007FFF55,
        34'h0003FFFEA, 34'h0001FFFFD, 34'h0000FFFFF, 34'h00007FFFF,
        34'h00003FFFF, 34'h00001FFFF, 34'h00000FFFF, 34'h000007FFF,
        34'h000003FFF, 34'h000001FFF, 34'h000000FFF, 34'h0000007FF,
        34'h0000003FF, 34'h0000001FF, 34'h0000000FF, 34'h00000007F
    };

    // Rotor that a pipeline slot belongs to.
    typedef enum logic [1:0] {
        ROTOR_A,
        ROTOR_B,
        ROTOR_C,
        ROTOR_D
    } rotor_t;

    // One vector travelling down the CORDIC chain.
    typedef struct packed {
        logic                  valid;
        rotor_t                rotor;
        logic                  zero;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [ZW-1:0]  z;
    } trm_vec_t;

endpackage

>>> sv/trm_feed.sv
// Input holding register, per-rotor force mixing and CORDIC pre-rotation.
module trm_feed (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // roll_force, pitch_force, yaw_force, x_force, y_force, z_force (lowest first)
    input  logic [trm_pkg::S_DATA_W-1:0]    s_tdata,
    output trm_pkg::trm_vec_t               vec_out
);
    import trm_pkg::*;

    logic [S_DATA_W-1:0]     item_reg;
    logic                    full_reg;
    rotor_t                  rotor_reg;

    logic                    a_valid_reg;
    rotor_t                  a_rotor_reg;
    logic signed [TVW-1:0]   a_tv_reg;
    logic signed [THW-1:0]   a_th_reg;

    trm_vec_t                vec_reg;

    logic signed [15:0]      f_roll, f_pitch, f_yaw, f_x, f_y, f_z;
    logic                    neg_r, neg_p;
    logic signed [17:0]      tv_mix, r_term, p_term;
    logic signed [17:0]      sh_mix, x_term, y_term;
    logic signed [THW-1:0]   th_mix;

    logic signed [THW-1:0]   th_rnd;
    logic signed [XW-1:0]    tv14, th14;
    trm_vec_t                vec_next;

    // A new item is taken when the chain advances and the holder is empty or issues its last rotor.
    assign s_tready = adv && (!full_reg || rotor_reg == ROTOR_D);

    assign f_roll  = item_reg[15:0];
    assign f_pitch = item_reg[31:16];
    assign f_yaw   = item_reg[47:32];
    assign f_x     = item_reg[63:48];
    assign f_y     = item_reg[79:64];
    assign f_z     = item_reg[95:80];

    // Sign pattern of the roll and pitch shares for the rotor being issued.
    always_comb
    begin
        case (rotor_reg)
            ROTOR_A:
            begin
                neg_r = 1'b1;
                neg_p = 1'b1;
            end
            ROTOR_B:
            begin
                neg_r = 1'b0;
                neg_p = 1'b1;
            end
            ROTOR_C:
            begin
                neg_r = 1'b0;
                neg_p = 1'b0;
            end
            default:
            begin
                neg_r = 1'b1;
                neg_p = 1'b0;
            end
        endcase
    end

    // Vertical and horizontal mixes; the x share follows the roll sign and y the
    // inverse of the pitch sign.
    always_comb
    begin
        r_term = neg_r ? -18'(f_roll)  : 18'(f_roll);
        p_term = neg_p ? -18'(f_pitch) : 18'(f_pitch);
        tv_mix = 18'(f_z) + r_term + p_term;
        x_term = neg_r ? -18'(f_x) : 18'(f_x);
        y_term = neg_p ? 18'(f_y)  : -18'(f_y);
        sh_mix = x_term + y_term;
        th_mix = THW'(sh_mix) * THW'(SQRT2_Q16) - (THW'(f_yaw) <<< 16);
    end

    // Item holder and rotor issue counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= 1'b0;
            rotor_reg <= ROTOR_A;
        end
        else if (adv)
        begin
            if (s_tvalid && s_tready)
            begin
                full_reg  <= 1'b1;
                rotor_reg <= ROTOR_A;
            end
            else if (full_reg)
            begin
                if (rotor_reg == ROTOR_D)
                begin
                    full_reg <= 1'b0;
                end
                else
                begin
                    rotor_reg <= rotor_t'(rotor_reg + 2'd1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s_tvalid && s_tready)
        begin
            item_reg <= s_tdata;
        end
    end

    // Mixing stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_rotor_reg <= ROTOR_A;
            a_tv_reg    <= '0;
            a_th_reg    <= '0;
        end
        else if (adv)
        begin
            a_valid_reg <= full_reg;
            a_rotor_reg <= rotor_reg;
            a_tv_reg    <= {tv_mix, 4'b0000};
            a_th_reg    <= th_mix;
        end
    end

    // Round Th to 14 fraction bits and fold a negative Tv into the right half plane.
    always_comb
    begin
        th_rnd         = a_th_reg + THW'(2048);
        th14           = XW'(th_rnd >>> 12);
        tv14           = XW'(a_tv_reg);
        vec_next.valid = a_valid_reg;
        vec_next.rotor = a_rotor_reg;
        vec_next.zero  = (tv14 == '0) && (th14 == '0);
        if (!tv14[XW-1])
        begin
            vec_next.x = tv14;
            vec_next.y = th14;
            vec_next.z = '0;
        end
        else if (!th14[XW-1])
        begin
            vec_next.x = th14;
            vec_next.y = -tv14;
            vec_next.z = HALF_PI_Q30;
        end
        else
        begin
            vec_next.x = -th14;
            vec_next.y = tv14;
            vec_next.z = -HALF_PI_Q30;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= '0;
        end
        else if (adv)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

>>> sv/trm_cell.sv
// One CORDIC vectoring micro-rotation with its pipeline register.
module trm_cell #(
    parameter int SHIFT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  trm_pkg::trm_vec_t    vec_in,
    output trm_pkg::trm_vec_t    vec_out
);
    import trm_pkg::*;

    logic signed [XW-1:0]  x_in, y_in, xs, ys;
    logic signed [ZW-1:0]  z_in, step_ang;
    trm_vec_t              vec_next;
    trm_vec_t              vec_reg;

    assign x_in     = vec_in.x;
    assign y_in     = vec_in.y;
    assign z_in     = vec_in.z;
    assign xs       = x_in >>> SHIFT;
    assign ys       = y_in >>> SHIFT;
    assign step_ang = signed'(ATAN_Q30[SHIFT]);

    // Rotate towards the x axis; the sign of y picks the direction.
    always_comb
    begin
        vec_next = vec_in;
        if (!y_in[XW-1])
        begin
            vec_next.x = x_in + ys;
            vec_next.y = y_in - xs;
            vec_next.z = z_in + step_ang;
        end
        else
        begin
            vec_next.x = x_in - ys;
            vec_next.y = y_in + xs;
            vec_next.z = z_in - step_ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= '0;
        end
        else if (adv)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

>>> sv/trm_post.sv
// Gain correction, rounding and saturation, and collection of four rotors per result.
module trm_post (
    input  logic                            clk,
    input  logic                            rst_n,
    input  trm_pkg::trm_vec_t               vec_in,
    output logic                            adv,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // thrust_a, thrust_b, thrust_c, thrust_d, tilt_a, tilt_b, tilt_c, tilt_d,
    // then zero fill (lowest first)
    output logic [trm_pkg::M_DATA_W-1:0]    m_tdata,
    // thrust_clipped
    output logic                            m_tuser
);
    import trm_pkg::*;

    logic                    p_valid_reg;
    rotor_t                  p_rotor_reg;
    logic                    p_zero_reg;
    logic [PRODW-1:0]        p_prod_reg;
    logic signed [ZW-1:0]    p_z_reg;

    logic signed [XW-1:0]    x_in;
    logic [XW-2:0]           x_clamp;

    logic [PRODW-1:0]        mag_rnd;
    logic [18:0]             mag;
    logic signed [ZW-1:0]    z_rnd;
    logic signed [15:0]      ang;
    logic                    clip_cur;
    logic [15:0]             thrust_cur;
    logic [14:0]             tilt_cur;

    logic [15:0]             slot_thrust_reg [3];
    logic [14:0]             slot_tilt_reg   [3];
    logic                    clip_acc_reg;

    logic                    m_tvalid_reg;
    logic [M_DATA_W-1:0]     m_tdata_reg;
    logic                    m_tuser_reg;

    // The whole chain moves when the output register is free or being emptied.
    assign adv = !m_tvalid_reg || m_tready;

    assign x_in    = vec_in.x;
    assign x_clamp = x_in[XW-1] ? '0 : x_in[XW-2:0];

    // Multiply by the inverse CORDIC gain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_rotor_reg <= ROTOR_A;
            p_zero_reg  <= 1'b0;
            p_prod_reg  <= '0;
            p_z_reg     <= '0;
        end
        else if (adv)
        begin
            p_valid_reg <= vec_in.valid;
            p_rotor_reg <= vec_in.rotor;
            p_zero_reg  <= vec_in.zero;
            p_prod_reg  <= PRODW'(x_clamp) * PRODW'(INV_GAIN_Q16);
            p_z_reg     <= vec_in.z;
        end
    end

    // Round both results half up to their output formats, saturate and clamp.
    always_comb
    begin
        mag_rnd = p_prod_reg + PRODW'(1 << 21);
        mag     = mag_rnd[PRODW-1:22];
        z_rnd   = p_z_reg + ZW'(1 << 17);
        ang     = z_rnd[ZW-1:18];
        if (ang > ANGLE_MAX)
        begin
            ang = ANGLE_MAX;
        end
        else if (ang < -ANGLE_MAX)
        begin
            ang = -ANGLE_MAX;
        end
        clip_cur   = 1'b0;
        thrust_cur = mag[15:0];
        if (mag[18:16] != 3'b000)
        begin
            thrust_cur = 16'hFFFF;
            clip_cur   = 1'b1;
        end
        tilt_cur = ang[14:0];
        // A zero vector gives zero thrust and zero angle.
        if (p_zero_reg)
        begin
            thrust_cur = '0;
            tilt_cur   = '0;
            clip_cur   = 1'b0;
        end
    end

    // Hold the first three rotors of an item until the fourth arrives.
    always_ff @(posedge clk)
    begin
        if (adv && p_valid_reg && p_rotor_reg != ROTOR_D)
        begin
            slot_thrust_reg[p_rotor_reg] <= thrust_cur;
            slot_tilt_reg[p_rotor_reg]   <= tilt_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_acc_reg <= 1'b0;
        end
        else if (adv && p_valid_reg)
        begin
            if (p_rotor_reg == ROTOR_A)
            begin
                clip_acc_reg <= clip_cur;
            end
            else
            begin
                clip_acc_reg <= clip_acc_reg | clip_cur;
            end
        end
    end

    // Output register: loaded when the last rotor of an item completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= p_valid_reg && p_rotor_reg == ROTOR_D;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && p_valid_reg && p_rotor_reg == ROTOR_D)
        begin
            m_tdata_reg <= {4'b0000, tilt_cur, slot_tilt_reg[2], slot_tilt_reg[1],
                            slot_tilt_reg[0], thrust_cur, slot_thrust_reg[2],
                            slot_thrust_reg[1], slot_thrust_reg[0]};
            m_tuser_reg <= clip_acc_reg | clip_cur;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> sv/tilt_rotor_thrust_mixer_unit.sv
// Top level of the tilt-rotor thrust mixer: feeder, CORDIC cell chain and result collector.
//
//  Channel  Direction  Payload
//  s_*      in         six signed Q6.10 force demands in tdata
//  m_*      out        four thrusts and four tilt angles in tdata, clip flag in tuser
//
//  An item's four rotors share one CORDIC chain, one rotor per cycle unless the chain is stalled.
//  A new item is taken in the cycle the previous one issues its last rotor.
//  A rotor passes the mixing register, the pre-rotation register, the cell chain, the gain and output registers.
//  Reset is asynchronous and clears all valid flags; no clearing pass is needed.
//  m_tready low with a result waiting freezes the whole chain and s_tready.
module tilt_rotor_thrust_mixer_unit #(
    parameter int CORDIC_STEPS = trm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // roll_force, pitch_force, yaw_force, x_force, y_force, z_force (lowest first)
    input  logic [trm_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // thrust_a, thrust_b, thrust_c, thrust_d, tilt_a, tilt_b, tilt_c, tilt_d,
    // then zero fill (lowest first)
    output logic [trm_pkg::M_DATA_W-1:0]    m_tdata,
    // thrust_clipped
    output logic                            m_tuser
);
    import trm_pkg::*;

    localparam int NUM_CELLS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    logic      adv;
    trm_vec_t  chain [NUM_CELLS+1];

    trm_feed u_feed (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .vec_out  (chain[0])
    );

    // One micro-rotation per cell, shift amount given by its place in the row.
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        trm_cell #(
            .SHIFT (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .vec_in  (chain[g]),
            .vec_out (chain[g+1])
        );
    end

    trm_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .vec_in   (chain[NUM_CELLS]),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef ASSERT_OFF
    // After an input transfer the feeder is busy with the remaining rotors.
    a_accept_cadence: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while rotors were still being issued");

    // Rotors of one item enter the chain back to back and in order.
    a_rotor_order: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && chain[0].valid && chain[0].rotor != ROTOR_D) |=>
        (chain[0].valid && chain[0].rotor == rotor_t'($past(chain[0].rotor) + 2'd1)))
        else $error("rotor sequence broken at the head of the chain");

    // A stall holds the tail of the chain.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(chain[NUM_CELLS]))
        else $error("chain moved during an output stall");
`endif

endmodule

>>> dv/tilt_rotor_thrust_mixer_unit_tb.sv
// Self-checking testbench for the tilt-rotor thrust mixer: stimulus, thrust allocation predictor and result checks.
`timescale 1ns / 1ps

module tilt_rotor_thrust_mixer_unit_tb;

    localparam int CORDIC_STEPS = trm_pkg::CORDIC_STEPS_DEF;
    localparam int ATAN_LEN     = 24;
    localparam int PIPE_DEPTH   = 7 + ((CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS);

    // Fixed-point constants of the allocation, kept independent of the design.
    localparam longint ROOT2_Q16        = 92682;
    localparam longint THRUST_GAIN_Q16  = 39797;
    localparam longint QUARTER_TURN_Q30 = 1686629713;
    localparam longint TILT_LIMIT       = 12868;
    localparam longint MAX_THRUST       = 65535;
    localparam int     MAX_REPORTS      = 20;

    // atan(2^-i) in Q2.30, truncated.
    localparam longint ARCTAN_Q30 [ATAN_LEN] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // Six force demands as they travel on the input stream.
    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] xf;
        logic signed [15:0] yf;
        logic signed [15:0] zf;
    } demand_t;

    // Thrusts, tilt angles and clip flag of one allocation.
    typedef struct packed {
        logic [3:0][15:0] thrust;
        logic [3:0][14:0] tilt;
        logic             clipped;
    } alloc_t;

    // Outcome of vectoring one rotor.
    typedef struct packed {
        logic        clip;
        logic [14:0] tilt;
        logic [15:0] thrust;
    } rotor_out_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [trm_pkg::S_DATA_W-1:0]   s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [trm_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           m_tuser;

    alloc_t pending_alloc [$];
    int     demands_sent;
    int     allocs_checked;
    int     reversed_rotors;
    int     mismatches;
    bit     tx_idle;
    bit     rx_idle;
    int     hold_off;

    tilt_rotor_thrust_mixer_unit #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 2 ns clock.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Magnitude and angle of one rotor's (Tv, Th) vector, both with 14 fraction bits.
    function automatic rotor_out_t resolve_rotor(input longint tv, input longint th);
        rotor_out_t o;
        longint     x;
        longint     y;
        longint     z;
        longint     t;
        longint     xs;
        longint     ys;
        longint     mag;
        longint     ang;
        int         steps;
        o = '0;
        x = tv;
        y = th;
        z = 0;
        if (tv == 0 && th == 0)
            return o;
        // A rotor pointing against the lift is turned by a quarter turn first.
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = QUARTER_TURN_Q30;
            end
            else
            begin
                t = x; x = -y; y = t; z = -QUARTER_TURN_Q30;
            end
        end
        steps = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
        // Vectoring: drive y to zero, shifts round towards minus infinity.
        for (int i = 0; i < steps; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + ARCTAN_Q30[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - ARCTAN_Q30[i];
            end
        end
        if (x < 0)
            x = 0;
        // Remove the CORDIC gain and round half up to Q8.8, saturating.
        mag = (x * THRUST_GAIN_Q16 + 64'sd2097152) >>> 22;
        if (mag > MAX_THRUST)
        begin
            mag = MAX_THRUST;
            o.clip = 1'b1;
        end
        o.thrust = mag[15:0];
        // Q2.30 to Q3.12 with rounding half up, then clamp to plus or minus pi.
        ang = (z + 64'sd131072) >>> 18;
        if (ang > TILT_LIMIT)
            ang = TILT_LIMIT;
        if (ang < -TILT_LIMIT)
            ang = -TILT_LIMIT;
        o.tilt = ang[14:0];
        return o;
    endfunction

    // Full allocation of one set of force demands over the four rotors.
    function automatic alloc_t allocate_thrust(input demand_t d);
        alloc_t     a;
        rotor_out_t ro;
        longint     r, p, yw, xf, yf, zf;
        longint     tv [4];
        longint     sh [4];
        longint     th_full;
        longint     th14;
        a = '0;
        r  = d.roll;
        p  = d.pitch;
        yw = d.yaw;
        xf = d.xf;
        yf = d.yf;
        zf = d.zf;
        tv[0] = zf - r - p;
        tv[1] = zf + r - p;
        tv[2] = zf + r + p;
        tv[3] = zf - r + p;
        sh[0] = -xf + yf;
        sh[1] = xf + yf;
        sh[2] = xf - yf;
        sh[3] = -xf - yf;
        for (int k = 0; k < 4; k++)
        begin
            th_full = sh[k] * ROOT2_Q16 - yw * 65536;
            th14    = (th_full + 2048) >>> 12;
            ro      = resolve_rotor(tv[k] * 16, th14);
            a.thrust[k] = ro.thrust;
            a.tilt[k]   = ro.tilt;
            a.clipped   = a.clipped | ro.clip;
        end
        return a;
    endfunction

    // Gap length in cycles: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll_dice;
        roll_dice = $urandom_range(0, 99);
        if (roll_dice < 60)
            return 0;
        if (roll_dice < 90)
            return $urandom_range(1, 3);
        if (roll_dice < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offers one demand from a falling edge and returns at a falling edge after the transfer.
    task automatic send_demand(input demand_t d);
        int gap;
        s_tdata  = {d.zf, d.yf, d.xf, d.yaw, d.pitch, d.roll};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_alloc.push_back(allocate_thrust(d));
        demands_sent++;
        @(negedge clk);
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_forces(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                               input logic signed [15:0] yaw, input logic signed [15:0] xf,
                               input logic signed [15:0] yf, input logic signed [15:0] zf);
        demand_t d;
        d = '{roll: roll, pitch: pitch, yaw: yaw, xf: xf, yf: yf, zf: zf};
        send_demand(d);
    endtask

    // One of a few interesting values or a value of any size.
    function automatic logic signed [15:0] pick_force(input int kind);
        logic signed [15:0] v;
        case (kind)
            0: v = 16'($urandom());
            1:
            begin
                v = 16'($urandom_range(0, 127));
                v = v - 16'sd64;
            end
            default:
                case ($urandom_range(0, 4))
                    0: v = 16'sh8000;
                    1: v = 16'sh7FFF;
                    2: v = 16'sh0000;
                    3: v = -16'sd1;
                    default: v = 16'sd1;
                endcase
        endcase
        return v;
    endfunction

    // Output sink: random stalls, plus a long hold-off when one is requested.
    initial
    begin : output_sink
        int stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready = 1'b0;
                hold_off--;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if (rx_idle && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Compare every output transfer with the oldest predicted allocation.
    always @(posedge clk)
    begin : result_monitor
        alloc_t want;
        bit     reversed;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_alloc.size() == 0)
            begin
                flag_mismatch("result with none outstanding", 1, 0);
            end
            else
            begin
                want     = pending_alloc.pop_front();
                reversed = 1'b0;
                for (int k = 0; k < 4; k++)
                begin
                    if (m_tdata[16*k +: 16] !== want.thrust[k])
                        flag_mismatch($sformatf("thrust of rotor %0d", k),
                                      m_tdata[16*k +: 16], want.thrust[k]);
                    if (m_tdata[64 + 15*k +: 15] !== want.tilt[k])
                        flag_mismatch($sformatf("tilt of rotor %0d", k),
                                      $signed(m_tdata[64 + 15*k +: 15]), $signed(want.tilt[k]));
                    if ($signed(want.tilt[k]) > 6434 || $signed(want.tilt[k]) < -6434)
                        reversed = 1'b1;
                end
                if (m_tdata[127:124] !== 4'b0000)
                    flag_mismatch("fill bits", m_tdata[127:124], 0);
                if (m_tuser !== want.clipped)
                    flag_mismatch("thrust_clipped", m_tuser, want.clipped);
                if (reversed)
                    reversed_rotors++;
                allocs_checked++;
            end
        end
    end

    // Extremes of every field, every rotor quadrant and the zero vector.
    task automatic test_corners();
        send_forces(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_forces(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_forces(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_forces(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF);
        // Pure downward demand: Th is zero with Tv negative, which gives pi.
        send_forces(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000);
        send_forces(16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0);
        send_forces(16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
        send_forces(16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0);
        send_forces(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0);
        send_forces(16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_forces(16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        // Negative Tv with Th positive, then with Th negative.
        send_forces(16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sh8000);
        send_forces(16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sh8000);
        send_forces(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1);
        send_forces(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0);
        send_forces(16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0);
        send_forces(16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, -16'sd1);
        // Largest vectors that the rotor signs allow.
        send_forces(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_forces(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_forces(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
        send_forces(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
        send_forces(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
    endtask

    // Random demands of all shapes with idling on both sides.
    task automatic test_random_traffic(input int count);
        demand_t d;
        int      shape;
        int      kind;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            shape = $urandom_range(0, 9);
            kind  = (shape == 6) ? 1 : (shape == 9) ? 2 : 0;
            d.roll  = pick_force(kind);
            d.pitch = pick_force(kind);
            d.yaw   = pick_force(kind);
            d.xf    = pick_force(kind);
            d.yf    = pick_force(kind);
            d.zf    = pick_force(kind);
            // Purely vertical or purely horizontal demands.
            if (shape == 7)
            begin
                d.yaw = '0; d.xf = '0; d.yf = '0;
            end
            if (shape == 8)
            begin
                d.roll = '0; d.pitch = '0; d.zf = '0;
            end
            send_demand(d);
        end
    endtask

    // Back-to-back transfers with neither side idling.
    task automatic test_streaming(input int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int n = 0; n < count; n++)
            send_forces(pick_force(0), pick_force(0), pick_force(0),
                        pick_force(0), pick_force(0), pick_force(0));
    endtask

    // The sink holds off for a long stretch while demands keep coming.
    task automatic test_backpressure(input int count);
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        hold_off = 400;
        for (int n = 0; n < count; n++)
            send_forces(pick_force(0), pick_force(0), pick_force(0),
                        pick_force(0), pick_force(0), pick_force(0));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        demands_sent    = 0;
        allocs_checked  = 0;
        reversed_rotors = 0;
        mismatches      = 0;
        tx_idle         = 1'b1;
        rx_idle         = 1'b1;
        hold_off        = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_corners();
        test_random_traffic(900);
        test_streaming(130);
        test_backpressure(100);
        s_tvalid = 1'b0;

        // Drain, then watch a while for any stray transfer.
        while (pending_alloc.size() > 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        $display("Sent %0d force demands (corners, random shapes, streaming, long sink stall);",
                 demands_sent);
        $display("checked %0d allocations, %0d of them with a rotor tilted past a quarter turn.",
                 allocs_checked, reversed_rotors);
        if (mismatches == 0)
            $display("** tilt_rotor_thrust_mixer_unit: PASSED **");
        else
            $display("** tilt_rotor_thrust_mixer_unit: FAILED **");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d allocations outstanding.", pending_alloc.size());
        $display("** tilt_rotor_thrust_mixer_unit: FAILED **");
        $finish;
    end

endmodule
